[src/c2s_pkg.sv]
// Package for the cartesian to spherical converter.
// Holds the datapath widths, pipeline depths, CORDIC angle table and shared types.
// Depends on nothing.
package c2s_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int FRAC_BITS     = 16;

  localparam int ANG_BITS  = 30;
  localparam int ANG_SH    = ANG_BITS - FRAC_BITS;
  localparam int GUARD_SH  = 24;
  localparam int CW        = 62;
  localparam int IN_W      = 34;
  localparam int ACC_W     = 34;
  localparam int ANG_W     = 19;

  localparam int SQ_STEPS  = 32;
  localparam int SQ_LAT    = SQ_STEPS + 1;
  localparam int FR_LAT    = 3;
  localparam int CO_LAT    = CORDIC_STAGES + 2;

  localparam logic signed [ACC_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               xy_zero;
  } vec_side_t;

  typedef struct packed {
    logic [31:0] radius;
    logic        xy_zero;
    logic        r_zero;
  } ang_side_t;

  function automatic logic signed [ACC_W-1:0] atan_step(input int i);
    logic signed [ACC_W-1:0] a;
    case (i)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048576;
      default: begin
        if (i <= 30) a = ACC_W'(64'sd1 <<< (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

[src/c2s_if.sv]
// Stream interfaces for the vector input and the spherical result.
// Depends on nothing.
interface c2s_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface c2s_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] radius;
  logic signed [18:0] azimuth;
  logic signed [18:0] elevation;
  modport source (output valid, radius, azimuth, elevation, input ready);
  modport sink   (input valid, radius, azimuth, elevation, output ready);
endinterface

[src/c2s_sqrt.sv]
// Two-lane pipelined integer square root, one result bit per stage, rounded to nearest.
// Depends on c2s_pkg.
module c2s_sqrt
  import c2s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_in,
  input  logic [63:0] s0_in,
  input  logic [63:0] s1_in,
  output logic        v_out,
  output logic [31:0] root0_out,
  output logic [31:0] root1_out
);

  logic [63:0] s_r    [0:1][0:SQ_STEPS];
  logic [33:0] rem_r  [0:1][0:SQ_STEPS];
  logic [31:0] root_r [0:1][0:SQ_STEPS];
  logic        v_r    [0:SQ_STEPS];
  logic [31:0] res_r  [0:1];
  logic        vo_r;

  always_comb begin
    s_r[0][0] = s0_in;
    s_r[1][0] = s1_in;
    rem_r[0][0] = '0;
    rem_r[1][0] = '0;
    root_r[0][0] = '0;
    root_r[1][0] = '0;
    v_r[0] = v_in;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (en) v_r[k+1] <= v_r[k];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [35:0] cand, trial;
      logic        take;
      assign cand  = {rem_r[l][k], s_r[l][k][63:62]};
      assign trial = {2'b00, root_r[l][k], 2'b01};
      assign take  = cand >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          s_r[l][k+1]    <= {s_r[l][k][61:0], 2'b00};
          rem_r[l][k+1]  <= take ? 34'(cand - trial) : cand[33:0];
          root_r[l][k+1] <= {root_r[l][k][30:0], take};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= v_r[SQ_STEPS];
  end

  for (genvar l = 0; l < 2; l++) begin : g_round
    always_ff @(posedge clk) begin
      if (en) begin
        res_r[l] <= root_r[l][SQ_STEPS] +
                    32'(rem_r[l][SQ_STEPS] > {2'b00, root_r[l][SQ_STEPS]});
      end
    end
  end

  assign v_out     = vo_r;
  assign root0_out = res_r[0];
  assign root1_out = res_r[1];

endmodule

[src/c2s_cordic.sv]
// Pipelined CORDIC vectoring unit giving atan2(y, x) in Q2.FRAC_BITS.
// Depends on c2s_pkg.
module c2s_cordic
  import c2s_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_in,
  input  logic signed [IN_W-1:0]  x_in,
  input  logic signed [IN_W-1:0]  y_in,
  output logic                    v_out,
  output logic signed [ANG_W-1:0] ang_out
);

  logic signed [CW-1:0]    x_r   [0:CORDIC_STAGES];
  logic signed [CW-1:0]    y_r   [0:CORDIC_STAGES];
  logic signed [ACC_W-1:0] acc_r [0:CORDIC_STAGES];
  logic                    v_r   [0:CORDIC_STAGES];
  logic signed [CW-1:0]    px, py;
  logic signed [ACC_W-1:0] pacc;
  logic signed [ANG_W-1:0] ang_r;
  logic                    vo_r;

  // Turn left-half-plane vectors by ninety degrees into the convergence range.
  always_comb begin
    px   = CW'(x_in);
    py   = CW'(y_in);
    pacc = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        px   = CW'(y_in);
        py   = -CW'(x_in);
        pacc = HALF_PI_Q30;
      end else begin
        px   = -CW'(y_in);
        py   = CW'(x_in);
        pacc = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= v_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= px <<< GUARD_SH;
      y_r[0]   <= py <<< GUARD_SH;
      acc_r[0] <= pacc;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (en) v_r[k+1] <= v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[k][CW-1]) begin
          x_r[k+1]   <= x_r[k] + dx;
          y_r[k+1]   <= y_r[k] - dy;
          acc_r[k+1] <= acc_r[k] + atan_step(k);
        end else begin
          x_r[k+1]   <= x_r[k] - dx;
          y_r[k+1]   <= y_r[k] + dy;
          acc_r[k+1] <= acc_r[k] - atan_step(k);
        end
      end
    end
  end

  // Clamp to [-pi, pi], then round half up to the output fraction.
  logic signed [ACC_W-1:0] clamped;
  logic signed [ACC_W:0]   biased;
  always_comb begin
    clamped = acc_r[CORDIC_STAGES];
    if (clamped > PI_Q30) clamped = PI_Q30;
    if (clamped < -PI_Q30) clamped = -PI_Q30;
    if (ANG_SH > 0) biased = ((ACC_W+1)'(clamped) + ((ACC_W+1)'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
    else biased = (ACC_W+1)'(clamped);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= v_r[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) ang_r <= biased[ANG_W-1:0];
  end

  assign v_out   = vo_r;
  assign ang_out = ang_r;

endmodule

[src/cartesian_to_spherical.sv]
// Top level of the cartesian to spherical converter.
// Depends on c2s_pkg, c2s_if, c2s_sqrt and c2s_cordic.
//
//   port     dir   words carried
//   in_ch    sink  vec_x, vec_y, vec_z  (signed Q16.16)
//   out_ch   src   radius (Q16.16), azimuth, elevation (signed Q2.16)
//
// One word enters per cycle while the output word is not held. The pipeline has
// three front stages (abs, squares, sums), one stage per root bit of the 32-bit
// square root plus rounding, then one stage per CORDIC iteration with a
// pre-rotation and an output stage. Reset clears only valid bits.
// The whole pipeline advances together; when the output word is held the
// pipeline freezes and in_ch.ready drops, so nothing is lost or repeated.
module cartesian_to_spherical
  import c2s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  c2s_in_if.sink    in_ch,
  c2s_out_if.source out_ch
);

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Front stages: magnitudes, squares, then the planar and total sums.
  logic [31:0] ax_r, ay_r, az_r;
  logic [63:0] sx_r, sy_r, sz_r;
  logic [63:0] planar_sq_r, total_sq_r;
  logic        fv_r [0:FR_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FR_LAT; i++) fv_r[i] <= 1'b0;
    end else if (en) begin
      fv_r[0] <= in_ch.valid;
      for (int i = 1; i < FR_LAT; i++) fv_r[i] <= fv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_ch.vec_x[31] ? 32'(-in_ch.vec_x) : in_ch.vec_x;
      ay_r <= in_ch.vec_y[31] ? 32'(-in_ch.vec_y) : in_ch.vec_y;
      az_r <= in_ch.vec_z[31] ? 32'(-in_ch.vec_z) : in_ch.vec_z;
      sx_r <= 64'(ax_r) * 64'(ax_r);
      sy_r <= 64'(ay_r) * 64'(ay_r);
      sz_r <= 64'(az_r) * 64'(az_r);
      planar_sq_r <= sx_r + sy_r;
      total_sq_r  <= sx_r + sy_r + sz_r;
    end
  end

  // The raw components ride alongside the front stages and the root.
  localparam int VD = FR_LAT + SQ_LAT;
  vec_side_t vd_r [0:VD-1];
  vec_side_t vd_in;
  always_comb begin
    vd_in.x       = in_ch.vec_x;
    vd_in.y       = in_ch.vec_y;
    vd_in.z       = in_ch.vec_z;
    vd_in.xy_zero = (in_ch.vec_x == '0) && (in_ch.vec_y == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= vd_in;
      for (int i = 1; i < VD; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  logic        sq_v;
  logic [31:0] planar, radius;

  c2s_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v_in      (fv_r[FR_LAT-1]),
    .s0_in     (planar_sq_r),
    .s1_in     (total_sq_r),
    .v_out     (sq_v),
    .root0_out (planar),
    .root1_out (radius)
  );

  // Azimuth works on (x, y); elevation on (planar length, z).
  logic                    az_v, el_v;
  logic signed [ANG_W-1:0] az_ang, el_ang;

  c2s_cordic u_cordic_az (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (sq_v),
    .x_in    (IN_W'(vd_r[VD-1].x)),
    .y_in    (IN_W'(vd_r[VD-1].y)),
    .v_out   (az_v),
    .ang_out (az_ang)
  );

  c2s_cordic u_cordic_el (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (sq_v),
    .x_in    (IN_W'({1'b0, planar})),
    .y_in    (IN_W'(vd_r[VD-1].z)),
    .v_out   (el_v),
    .ang_out (el_ang)
  );

  // Radius and the zero cases follow the angle pipeline.
  ang_side_t ad_r [0:CO_LAT-1];
  ang_side_t ad_in;
  always_comb begin
    ad_in.radius  = radius;
    ad_in.xy_zero = vd_r[VD-1].xy_zero;
    ad_in.r_zero  = (radius == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r[0] <= ad_in;
      for (int i = 1; i < CO_LAT; i++) ad_r[i] <= ad_r[i-1];
    end
  end

  assign out_ch.valid     = az_v && el_v;
  assign out_ch.radius    = ad_r[CO_LAT-1].radius;
  assign out_ch.azimuth   = (ad_r[CO_LAT-1].r_zero || ad_r[CO_LAT-1].xy_zero) ? '0 : az_ang;
  assign out_ch.elevation = ad_r[CO_LAT-1].r_zero ? '0 : el_ang;

endmodule
